// File: rtl/fbma_pkg.sv
package fbma_pkg;

   localparam int WORD_W    = 32;
   localparam int COUNT_W   = 18;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'b1;

   localparam logic OP_MAP      = 1'b0;
   localparam logic OP_NEW_FILE = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic [0:0] {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic borrow;
      logic zero;
   } alu_flags_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEL,
      ST_SPLIT,
      ST_PRD,
      ST_PCHK,
      ST_ALIM,
      ST_AADD,
      ST_CLR,
      ST_IRD,
      ST_ICHK,
      ST_RESP
   } fbma_state_type;

   // Which pointer the current lookup or allocation works on.
   typedef enum logic [1:0] {
      TGT_DIRECT,
      TGT_IPTR,
      TGT_ENTRY
   } fbma_tgt_type;

endpackage

// File: rtl/fbma_alu.sv
module fbma_alu (
   input  logic [fbma_pkg::WORD_W-1:0] opa,
   input  logic [fbma_pkg::WORD_W-1:0] opb,
   input  fbma_pkg::alu_op_type        op,
   output logic [fbma_pkg::WORD_W-1:0] res,
   output fbma_pkg::alu_flags_type     flags
);

   logic [fbma_pkg::WORD_W-1:0] b_eff;
   logic                        cin;
   logic [fbma_pkg::WORD_W:0]   sum;

   always_comb begin
      case (op)
         fbma_pkg::ALU_SUB: begin
            b_eff = ~opb;
            cin   = 1'b1;
         end
         default: begin
            b_eff = opb;
            cin   = 1'b0;
         end
      endcase
      sum = {1'b0, opa} + {1'b0, b_eff} + {{fbma_pkg::WORD_W{1'b0}}, cin};
   end

   assign res          = sum[fbma_pkg::WORD_W-1:0];
   // A subtraction borrows when there is no carry out of the top bit.
   assign flags.borrow = cin & ~sum[fbma_pkg::WORD_W];
   assign flags.zero   = (sum[fbma_pkg::WORD_W-1:0] == '0);

endmodule

// File: rtl/fbma_ptr_table.sv
module fbma_ptr_table #(
   parameter int SLOTS = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fbma_pkg::mem_ctl_type       ctl,
   input  logic                        clear_all,
   input  logic [$clog2(SLOTS)-1:0]    addr,
   input  logic [fbma_pkg::WORD_W-1:0] wdata,
   output logic [fbma_pkg::WORD_W-1:0] rdata
);

   logic [fbma_pkg::WORD_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]            valid_ff;
   logic [fbma_pkg::WORD_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;

   // A slot without its valid bit reads as a missing pointer.
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[addr];
         rd_valid_ff <= valid_ff[addr];
      end
   end

   assign rdata = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: rtl/fbma_ind_ram.sv
module fbma_ind_ram #(
   parameter int WORDS = 128
) (
   input  logic                        clock,
   input  fbma_pkg::mem_ctl_type       ctl,
   input  logic [$clog2(WORDS)-1:0]    addr,
   input  logic [fbma_pkg::WORD_W-1:0] wdata,
   output logic [fbma_pkg::WORD_W-1:0] rdata
);

   logic [fbma_pkg::WORD_W-1:0] mem [WORDS];
   logic [fbma_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

// File: rtl/file_block_map_allocator.sv
// Flow of a request: new_file and an offset out of range answer after the range check; a mapped
// offset selects a direct slot or splits into an indirect slot and entry, reads the pointer,
// and for an indirect entry also reads the entry; a zero pointer takes a block if one is free,
// and taking an indirect block clears its BLOCK_BYTES/4 entries.
// One shared 32-bit add/subtract unit serves these steps; one request is in flight at a time,
// and the next request beat is taken in the cycle after the result is loaded. Reset clears the
// pointer valid bits and the allocation count, with no sweep.
module file_block_map_allocator #(
   parameter int BLOCK_BYTES    = 512,
   parameter int DIRECT_SLOTS   = 12,
   parameter int INDIRECT_SLOTS = 1,
   parameter int DATA_BLOCKS    = 131072
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [31:0]                    req_byte_offset,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [31:0]                    rsp_block_number,
   output logic [1:0]                     rsp_status,
   output logic [1:0]                     rsp_allocated_count,
   input  logic                           csr_wr_en,
   input  logic [fbma_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wr_data
);

   localparam int PTRS           = BLOCK_BYTES / 4;
   localparam int TABLE_SLOTS    = DIRECT_SLOTS + INDIRECT_SLOTS;
   localparam int IND_WORDS      = INDIRECT_SLOTS * PTRS;
   localparam int MAX_BLOCKS     = DIRECT_SLOTS + IND_WORDS;
   localparam int MAX_FILE_BYTES = MAX_BLOCKS * BLOCK_BYTES;
   localparam int QW  = $clog2(MAX_BLOCKS);
   localparam int BB_SHIFT = $clog2(BLOCK_BYTES);
   localparam int TW  = $clog2(TABLE_SLOTS);
   localparam int IAW = $clog2(IND_WORDS);
   localparam int PW  = $clog2(PTRS);
   localparam int IW  = (INDIRECT_SLOTS > 1) ? $clog2(INDIRECT_SLOTS) : 1;
   localparam int FW  = $clog2(DATA_BLOCKS + 1);
   localparam logic [FW-1:0] LIMIT_RESET =
      (DATA_BLOCKS > 131072) ? FW'(131072) : FW'(DATA_BLOCKS);

   fbma_pkg::fbma_state_type state_ff, state_in;
   fbma_pkg::fbma_tgt_type   tgt_ff, tgt_in;

   logic            op_ff, op_in;
   logic [31:0]     off_ff, off_in;
   logic [QW-1:0]   quot_ff, quot_in;
   logic [QW-1:0]   rel_ff, rel_in;
   logic [IW-1:0]   ind_ff, ind_in;
   logic [TW-1:0]   slot_ff, slot_in;
   logic [IAW-1:0]  ent_addr_ff, ent_addr_in;
   logic [IAW-1:0]  ind_base_ff, ind_base_in;
   logic [PW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [31:0]     blk_ff, blk_in;
   logic [1:0]      status_ff, status_in;
   logic [1:0]      taken_ff, taken_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [31:0]     start_ff, start_in;
   logic [FW-1:0]   limit_ff, limit_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_blk_ff, rsp_blk_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [1:0]      rsp_taken_ff, rsp_taken_in;

   logic [31:0]                   alu_a, alu_b, alu_res;
   fbma_pkg::alu_op_type          alu_op;
   fbma_pkg::alu_flags_type       alu_flags;
   fbma_pkg::mem_ctl_type         ptr_ctl, ind_ctl;
   logic                          ptr_clear;
   logic [31:0]                   ptr_rdata, ind_rdata, ind_wdata;
   logic [IAW-1:0]                ind_addr;
   logic                          split_more;
   logic                          out_free;
   logic [fbma_pkg::COUNT_W-1:0]  csr_count;

   // Taken blocks always form a prefix of the bitmap, so a fill count stands for it.
   assign split_more = !alu_flags.borrow && (ind_ff != IW'(INDIRECT_SLOTS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_count  = csr_wr_data[fbma_pkg::COUNT_W-1:0];

   fbma_alu u_alu (
      .opa   (alu_a),
      .opb   (alu_b),
      .op    (alu_op),
      .res   (alu_res),
      .flags (alu_flags)
   );

   fbma_ptr_table #(
      .SLOTS (TABLE_SLOTS)
   ) u_ptr_table (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ptr_ctl),
      .clear_all (ptr_clear),
      .addr      (slot_ff),
      .wdata     (alu_res),
      .rdata     (ptr_rdata)
   );

   fbma_ind_ram #(
      .WORDS (IND_WORDS)
   ) u_ind_ram (
      .clock (clock),
      .ctl   (ind_ctl),
      .addr  (ind_addr),
      .wdata (ind_wdata),
      .rdata (ind_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbma_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fbma_pkg::ST_CHECK;
            end
         end
         fbma_pkg::ST_CHECK: begin
            if (op_ff == fbma_pkg::OP_NEW_FILE || !alu_flags.borrow) begin
               state_in = fbma_pkg::ST_RESP;
            end else begin
               state_in = fbma_pkg::ST_SEL;
            end
         end
         fbma_pkg::ST_SEL: begin
            state_in = alu_flags.borrow ? fbma_pkg::ST_PRD : fbma_pkg::ST_SPLIT;
         end
         fbma_pkg::ST_SPLIT: begin
            if (!split_more) begin
               state_in = fbma_pkg::ST_PRD;
            end
         end
         fbma_pkg::ST_PRD: begin
            state_in = fbma_pkg::ST_PCHK;
         end
         fbma_pkg::ST_PCHK: begin
            if (alu_flags.zero) begin
               state_in = fbma_pkg::ST_ALIM;
            end else if (tgt_ff == fbma_pkg::TGT_IPTR) begin
               state_in = fbma_pkg::ST_IRD;
            end else begin
               state_in = fbma_pkg::ST_RESP;
            end
         end
         fbma_pkg::ST_ALIM: begin
            state_in = alu_flags.borrow ? fbma_pkg::ST_AADD : fbma_pkg::ST_RESP;
         end
         fbma_pkg::ST_AADD: begin
            state_in = (tgt_ff == fbma_pkg::TGT_IPTR) ? fbma_pkg::ST_CLR : fbma_pkg::ST_RESP;
         end
         fbma_pkg::ST_CLR: begin
            if (clr_cnt_ff == PW'(PTRS - 1)) begin
               state_in = fbma_pkg::ST_ALIM;
            end
         end
         fbma_pkg::ST_IRD: begin
            state_in = fbma_pkg::ST_ICHK;
         end
         fbma_pkg::ST_ICHK: begin
            state_in = alu_flags.zero ? fbma_pkg::ST_ALIM : fbma_pkg::ST_RESP;
         end
         fbma_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = fbma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbma_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: shared unit operands and memory controls.
   always_comb begin
      alu_a     = '0;
      alu_b     = '0;
      alu_op    = fbma_pkg::ALU_SUB;
      ptr_ctl   = '0;
      ptr_clear = 1'b0;
      ind_ctl   = '0;
      ind_addr  = ent_addr_ff;
      ind_wdata = alu_res;
      req_stall = 1'b1;
      case (state_ff)
         fbma_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         fbma_pkg::ST_CHECK: begin
            alu_a     = off_ff;
            alu_b     = 32'(MAX_FILE_BYTES);
            ptr_clear = (op_ff == fbma_pkg::OP_NEW_FILE);
         end
         fbma_pkg::ST_SEL: begin
            alu_a = 32'(quot_ff);
            alu_b = 32'(DIRECT_SLOTS);
         end
         fbma_pkg::ST_SPLIT: begin
            alu_a = 32'(rel_ff);
            alu_b = 32'(PTRS);
         end
         fbma_pkg::ST_PRD: begin
            ptr_ctl.rd_en = 1'b1;
         end
         fbma_pkg::ST_PCHK: begin
            alu_a = ptr_rdata;
         end
         fbma_pkg::ST_ALIM: begin
            alu_a = 32'(fill_ff);
            alu_b = 32'(limit_ff);
         end
         fbma_pkg::ST_AADD: begin
            alu_a  = start_ff;
            alu_b  = 32'(fill_ff);
            alu_op = fbma_pkg::ALU_ADD;
            if (tgt_ff == fbma_pkg::TGT_ENTRY) begin
               ind_ctl.wr_en = 1'b1;
            end else begin
               ptr_ctl.wr_en = 1'b1;
            end
         end
         fbma_pkg::ST_CLR: begin
            ind_ctl.wr_en = 1'b1;
            ind_addr      = ind_base_ff + IAW'(clr_cnt_ff);
            ind_wdata     = '0;
         end
         fbma_pkg::ST_IRD: begin
            ind_ctl.rd_en = 1'b1;
         end
         fbma_pkg::ST_ICHK: begin
            alu_a = ind_rdata;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      op_in       = op_ff;
      off_in      = off_ff;
      quot_in     = quot_ff;
      rel_in      = rel_ff;
      ind_in      = ind_ff;
      slot_in     = slot_ff;
      ent_addr_in = ent_addr_ff;
      ind_base_in = ind_base_ff;
      clr_cnt_in  = clr_cnt_ff;
      tgt_in      = tgt_ff;
      blk_in      = blk_ff;
      status_in   = status_ff;
      taken_in    = taken_ff;
      fill_in     = fill_ff;
      start_in    = start_ff;
      limit_in    = limit_ff;

      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_blk_in    = rsp_blk_ff;
      rsp_status_in = rsp_status_ff;
      rsp_taken_in  = rsp_taken_ff;

      if (csr_wr_en) begin
         case (csr_index)
            fbma_pkg::CSR_DATA_START: begin
               start_in = csr_wr_data;
            end
            fbma_pkg::CSR_BLOCK_COUNT: begin
               if ({14'd0, csr_count} > 32'(DATA_BLOCKS)) begin
                  limit_in = FW'(DATA_BLOCKS);
               end else begin
                  limit_in = FW'(csr_count);
               end
            end
            default: begin
               start_in = start_ff;
            end
         endcase
      end

      case (state_ff)
         fbma_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_opcode;
               off_in = req_byte_offset;
            end
         end
         fbma_pkg::ST_CHECK: begin
            blk_in    = '0;
            status_in = fbma_pkg::STAT_OK;
            taken_in  = '0;
            if (op_ff != fbma_pkg::OP_NEW_FILE && !alu_flags.borrow) begin
               status_in = fbma_pkg::STAT_RANGE;
            end
            // Block sizes are powers of two, so the block index is a plain shift.
            quot_in = QW'(off_ff >> BB_SHIFT);
         end
         fbma_pkg::ST_SEL: begin
            slot_in = quot_ff[TW-1:0];
            tgt_in  = fbma_pkg::TGT_DIRECT;
            rel_in  = alu_res[QW-1:0];
            ind_in  = '0;
         end
         fbma_pkg::ST_SPLIT: begin
            if (split_more) begin
               rel_in = alu_res[QW-1:0];
               ind_in = ind_ff + IW'(1);
            end else begin
               slot_in     = TW'(DIRECT_SLOTS) + TW'(ind_ff);
               ind_base_in = IAW'(ind_ff) * IAW'(PTRS);
               ent_addr_in = IAW'(ind_ff) * IAW'(PTRS) + IAW'(rel_ff);
               tgt_in      = fbma_pkg::TGT_IPTR;
            end
         end
         fbma_pkg::ST_PCHK: begin
            if (!alu_flags.zero) begin
               if (tgt_ff == fbma_pkg::TGT_IPTR) begin
                  tgt_in = fbma_pkg::TGT_ENTRY;
               end else begin
                  blk_in = ptr_rdata;
               end
            end
         end
         fbma_pkg::ST_ALIM: begin
            if (!alu_flags.borrow) begin
               status_in = fbma_pkg::STAT_FULL;
            end
         end
         fbma_pkg::ST_AADD: begin
            fill_in  = fill_ff + FW'(1);
            taken_in = taken_ff + 2'd1;
            if (tgt_ff == fbma_pkg::TGT_IPTR) begin
               clr_cnt_in = '0;
            end else begin
               blk_in = alu_res;
            end
         end
         fbma_pkg::ST_CLR: begin
            clr_cnt_in = clr_cnt_ff + PW'(1);
            if (clr_cnt_ff == PW'(PTRS - 1)) begin
               tgt_in = fbma_pkg::TGT_ENTRY;
            end
         end
         fbma_pkg::ST_ICHK: begin
            if (!alu_flags.zero) begin
               blk_in = ind_rdata;
            end
         end
         fbma_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_blk_in    = blk_ff;
               rsp_status_in = status_ff;
               rsp_taken_in  = taken_ff;
            end
         end
         default: begin
            tgt_in = tgt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbma_pkg::ST_IDLE;
         fill_ff      <= '0;
         start_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         start_ff     <= start_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      off_ff        <= off_in;
      quot_ff       <= quot_in;
      rel_ff        <= rel_in;
      ind_ff        <= ind_in;
      slot_ff       <= slot_in;
      ent_addr_ff   <= ent_addr_in;
      ind_base_ff   <= ind_base_in;
      clr_cnt_ff    <= clr_cnt_in;
      tgt_ff        <= tgt_in;
      blk_ff        <= blk_in;
      status_ff     <= status_in;
      taken_ff      <= taken_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_taken_ff  <= rsp_taken_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_block_number    = rsp_blk_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_allocated_count = rsp_taken_ff;

   // Only the add step of an allocation may move the fill count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != fbma_pkg::ST_AADD) |=> $stable(fill_ff))
      else $error("fill count changed outside an allocation");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbma_pkg::ST_RESP && status_ff != fbma_pkg::STAT_OK) |-> (blk_ff == '0))
      else $error("error result carries a nonzero block number");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbma_pkg::ST_RESP && status_ff == fbma_pkg::STAT_RANGE) |->
      (taken_ff == 2'd0))
      else $error("out-of-range request took a block");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DATA_BLOCKS))
      else $error("fill count beyond bitmap size");

endmodule

// File: tb/sv/file_block_map_allocator_tb.sv
`timescale 1ns / 100ps

module file_block_map_allocator_tb;

   localparam int BLOCK_BYTES    = 512;
   localparam int DIRECT_SLOTS   = 12;
   localparam int INDIRECT_SLOTS = 1;
   localparam int DATA_BLOCKS    = 131072;
   localparam int PTRS_PER_BLOCK = BLOCK_BYTES / 4;
   localparam int TABLE_SLOTS    = DIRECT_SLOTS + INDIRECT_SLOTS;
   localparam int INDIRECT_WORDS = INDIRECT_SLOTS * PTRS_PER_BLOCK;
   localparam int MAX_FILE_BYTES = (DIRECT_SLOTS + INDIRECT_WORDS) * BLOCK_BYTES;
   localparam int MAX_GAP        = 13;

   typedef struct packed {
      logic [31:0] block_number;
      logic [1:0]  status;
      logic [1:0]  allocated_count;
   } map_result_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic                           req_opcode;
   logic [31:0]                    req_byte_offset;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [31:0]                    rsp_block_number;
   logic [1:0]                     rsp_status;
   logic [1:0]                     rsp_allocated_count;
   logic                           csr_wr_en;
   logic [fbma_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                    csr_wr_data;

   // Mirror of the block's state. Blocks are never freed and always taken lowest
   // first, so the used part of the bitmap is a prefix and a count describes it.
   logic [31:0]   data_start_reg  = '0;
   logic [17:0]   block_count_reg = 18'd131072;
   int unsigned   blocks_used     = 0;
   logic [31:0]   file_ptrs [TABLE_SLOTS]        = '{default: '0};
   logic [31:0]   indirect_ptrs [INDIRECT_WORDS] = '{default: '0};

   map_result_type pending_maps [$];
   bit            sender_idles     = 1'b1;
   bit            receiver_idles   = 1'b1;
   int unsigned   long_hold_cycles = 0;
   int unsigned   mismatch_count   = 0;
   int unsigned   request_count    = 0;
   int unsigned   new_file_count   = 0;
   int unsigned   range_count      = 0;
   int unsigned   full_count       = 0;
   int unsigned   taken_count      = 0;

   file_block_map_allocator DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_byte_offset     (req_byte_offset),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_block_number    (rsp_block_number),
      .rsp_status          (rsp_status),
      .rsp_allocated_count (rsp_allocated_count),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Resolves one pointer: a zero pointer takes the next free block if one is left.
   function automatic void fill_pointer(inout logic [31:0] ptr, inout map_result_type res);
      int unsigned usable;
      usable = (block_count_reg > DATA_BLOCKS) ? DATA_BLOCKS : block_count_reg;
      if (ptr == '0) begin
         if (blocks_used < usable) begin
            ptr = data_start_reg + 32'(blocks_used);
            blocks_used++;
            res.allocated_count = res.allocated_count + 2'd1;
         end else begin
            res.status = fbma_pkg::STAT_FULL;
         end
      end
      res.block_number = (res.status == fbma_pkg::STAT_OK) ? ptr : '0;
   endfunction

   function automatic map_result_type predict_lookup(logic opcode, logic [31:0] offset);
      map_result_type res;
      int unsigned blk_idx;
      int unsigned rel;
      int unsigned ind;
      int unsigned ent;
      logic [1:0]  taken_before;
      res = '0;
      if (opcode == fbma_pkg::OP_NEW_FILE) begin
         foreach (file_ptrs[i]) file_ptrs[i] = '0;
      end else if (offset >= MAX_FILE_BYTES) begin
         res.status = fbma_pkg::STAT_RANGE;
      end else begin
         blk_idx = offset / BLOCK_BYTES;
         if (blk_idx < DIRECT_SLOTS) begin
            fill_pointer(file_ptrs[blk_idx], res);
         end else begin
            rel = blk_idx - DIRECT_SLOTS;
            ind = rel / PTRS_PER_BLOCK;
            ent = rel % PTRS_PER_BLOCK;
            if (ind >= INDIRECT_SLOTS) ind = INDIRECT_SLOTS - 1;
            taken_before = res.allocated_count;
            fill_pointer(file_ptrs[DIRECT_SLOTS + ind], res);
            // A freshly taken indirect block starts with all its entries empty.
            if (res.allocated_count != taken_before) begin
               for (int k = 0; k < PTRS_PER_BLOCK; k++)
                  indirect_ptrs[ind * PTRS_PER_BLOCK + k] = '0;
            end
            if (res.status == fbma_pkg::STAT_OK)
               fill_pointer(indirect_ptrs[ind * PTRS_PER_BLOCK + ent], res);
         end
      end
      return res;
   endfunction

   task automatic send_request(input logic opcode, input logic [31:0] offset);
      int unsigned gap;
      map_result_type res;
      gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= opcode;
      req_byte_offset <= offset;
      do @(posedge clock); while (req_stall);
      res = predict_lookup(opcode, offset);
      pending_maps.push_back(res);
      request_count++;
      if (opcode == fbma_pkg::OP_NEW_FILE) new_file_count++;
      if (res.status == fbma_pkg::STAT_RANGE) range_count++;
      if (res.status == fbma_pkg::STAT_FULL) full_count++;
      taken_count += res.allocated_count;
   endtask

   // Stops offering beats and waits until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_maps.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [fbma_pkg::CSR_IDX_W-1:0] index,
                            input logic [31:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      if (index == fbma_pkg::CSR_DATA_START) data_start_reg = value;
      else block_count_reg = value[17:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_offset();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return $urandom_range(0, DIRECT_SLOTS * BLOCK_BYTES - 1);
      if (sel < 93) return $urandom_range(0, MAX_FILE_BYTES - 1);
      if (sel < 97) return $urandom_range(MAX_FILE_BYTES, MAX_FILE_BYTES + 1024);
      return $urandom();
   endfunction

   // Mostly lookups within a file, with an occasional switch to a new file.
   task automatic send_random_requests(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 4) send_request(fbma_pkg::OP_NEW_FILE, $urandom());
         else send_request(fbma_pkg::OP_MAP, pick_offset());
      end
   endtask

   task automatic test_map_basics();
      // With the reset base of zero the first block is number 0, which reads as
      // missing, so the same offset takes a second block.
      send_request(fbma_pkg::OP_MAP, 32'd0);
      send_request(fbma_pkg::OP_MAP, 32'd0);
      send_request(fbma_pkg::OP_MAP, 32'd511);
      send_request(fbma_pkg::OP_MAP, 32'd512);
      send_request(fbma_pkg::OP_MAP, 32'(DIRECT_SLOTS * BLOCK_BYTES - 1));
      send_request(fbma_pkg::OP_MAP, 32'(DIRECT_SLOTS * BLOCK_BYTES));
      send_request(fbma_pkg::OP_MAP, 32'(MAX_FILE_BYTES - 1));
      send_request(fbma_pkg::OP_MAP, 32'(MAX_FILE_BYTES));
      send_request(fbma_pkg::OP_MAP, 32'hFFFF_FFFF);
      send_request(fbma_pkg::OP_NEW_FILE, 32'hFFFF_FFFF);
      send_request(fbma_pkg::OP_MAP, 32'(DIRECT_SLOTS * BLOCK_BYTES));
   endtask

   task automatic test_block_number_wrap();
      // Place the next block exactly on the wrap to zero.
      write_csr(fbma_pkg::CSR_DATA_START, 32'h0 - 32'(blocks_used));
      send_request(fbma_pkg::OP_NEW_FILE, 32'h0);
      send_request(fbma_pkg::OP_MAP, 32'd512);
      send_request(fbma_pkg::OP_MAP, 32'd512);
      write_csr(fbma_pkg::CSR_DATA_START, 32'hFFFF_FFFF);
      send_request(fbma_pkg::OP_MAP, 32'd1024);
   endtask

   task automatic test_bitmap_exhaustion();
      write_csr(fbma_pkg::CSR_BLOCK_COUNT, 32'(blocks_used));
      send_request(fbma_pkg::OP_MAP, 32'd1536);
      // Room for one block only: the indirect block is taken, the data block fails.
      write_csr(fbma_pkg::CSR_BLOCK_COUNT, 32'(blocks_used + 1));
      send_request(fbma_pkg::OP_NEW_FILE, 32'h0);
      send_request(fbma_pkg::OP_MAP, 32'd7000);
      write_csr(fbma_pkg::CSR_BLOCK_COUNT, 32'd0);
      send_request(fbma_pkg::OP_MAP, 32'd0);
      write_csr(fbma_pkg::CSR_BLOCK_COUNT, 32'd1);
      send_request(fbma_pkg::OP_MAP, 32'd2048);
      write_csr(fbma_pkg::CSR_BLOCK_COUNT, 32'h0003_FFFF);
      send_request(fbma_pkg::OP_MAP, 32'd0);
      write_csr(fbma_pkg::CSR_BLOCK_COUNT, 32'(DATA_BLOCKS));
   endtask

   task automatic test_random_traffic();
      write_csr(fbma_pkg::CSR_DATA_START, $urandom());
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      send_random_requests(110);

      write_csr(fbma_pkg::CSR_DATA_START, 32'h0);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      send_random_requests(100);

      // Upper bits of the count write are ignored by the register.
      write_csr(fbma_pkg::CSR_BLOCK_COUNT,
                {14'($urandom()), 18'(blocks_used + $urandom_range(30, 80))});
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      send_random_requests(110);

      write_csr(fbma_pkg::CSR_BLOCK_COUNT, 32'(DATA_BLOCKS));
      write_csr(fbma_pkg::CSR_DATA_START,
                32'h0 - 32'(blocks_used) - 32'($urandom_range(0, 20)));
      receiver_idles = 1'b0;
      send_random_requests(100);
      receiver_idles = 1'b1;
   endtask

   task automatic test_backpressure();
      wait_drained();
      long_hold_cycles = 300;
      sender_idles     = 1'b0;
      send_random_requests(20);
      sender_idles = 1'b1;
      // The sender stops here until every outstanding result has come back.
      wait_drained();
   endtask

   // Result side: when receiver_idles is set, stalls for a random hold before each beat, or
   // for a long stretch when one is requested.
   initial begin
      int unsigned hold;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
         if (long_hold_cycles > 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      map_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_maps.size() == 0) begin
            $error("result beat with no request outstanding: block_number %h", rsp_block_number);
            mismatch_count++;
         end else begin
            want = pending_maps.pop_front();
            if (rsp_block_number !== want.block_number) begin
               $error("block_number: expected %h, actual %h", want.block_number,
                      rsp_block_number);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_allocated_count !== want.allocated_count) begin
               $error("allocated_count: expected %0d, actual %0d", want.allocated_count,
                      rsp_allocated_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= fbma_pkg::OP_MAP;
      req_byte_offset <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= fbma_pkg::CSR_DATA_START;
      csr_wr_data     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_map_basics();
      test_block_number_wrap();
      test_bitmap_exhaustion();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (200) @(posedge clock);
      $display("Sent %0d requests: %0d new files, %0d offsets out of range, %0d full bitmap.",
               request_count, new_file_count, range_count, full_count);
      $display("Blocks taken from the bitmap: %0d.", taken_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
